// File: hdl/shfs_pkg.sv
// shared types, codes and constants of the sync header frame splitter
package shfs_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int WIN_DEPTH    = HEADER_BYTES - 1;

  localparam int POS_W   = 17;
  localparam int PAIRS_W = 15;
  localparam int FNUM_W  = 16;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 3;

  localparam logic [FNUM_W-1:0] FNUM_NONE = 16'hFFFF;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_FRAME_BYTES = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SPC         = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SYNC_FIRST  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SYNC_SECOND = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_HEADER_TAG  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PAIR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0]   frame_bytes;
    logic [PAIRS_W-1:0] samples_per_channel;
    logic [7:0]         sync_first;
    logic [7:0]         sync_second;
    logic [7:0]         header_tag;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FNUM_W-1:0]  frame_number;
    logic               frame_lost;
    logic [7:0]         sample_a;
    logic [7:0]         sample_b;
    logic [PAIRS_W-1:0] pair_index;
    logic               frame_complete;
    logic [FNUM_W-1:0]  completed_frames;
    logic               header_seen;
    logic               last_of_run;
  } res_t;

endpackage

// File: hdl/shfs_core.sv
// per-byte deframing logic: header hunt, pair split and buffer end
module shfs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  shfs_pkg::cfg_t cfg,
  input  logic           byte_take,
  input  logic [7:0]     data_byte,
  output logic           push0,
  output logic           push1,
  output shfs_pkg::res_t res0,
  output shfs_pkg::res_t res1
);

  logic [7:0]                   win_r   [shfs_pkg::WIN_DEPTH];
  logic [7:0]                   win_nxt [shfs_pkg::WIN_DEPTH];
  logic [shfs_pkg::POS_W-1:0]   pos_r, pos_nxt;
  shfs_pkg::phase_t             phase_r, phase_nxt;
  logic [shfs_pkg::PAIRS_W-1:0] pair_r, pair_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [7:0]                   pend_b_r, pend_b_nxt;
  logic [shfs_pkg::FNUM_W-1:0]  prev_r, prev_nxt;
  logic [shfs_pkg::FNUM_W-1:0]  cnt_r, cnt_nxt;

  logic [shfs_pkg::POS_W-1:0]   fb;
  logic [7:0]                   hdr_sum;
  logic                         hdr_hit;
  logic [shfs_pkg::FNUM_W-1:0]  hdr_id;
  logic [shfs_pkg::FNUM_W-1:0]  id_diff;
  logic                         buf_end;
  shfs_pkg::res_t               end_res;

  always_comb begin
    fb      = (cfg.frame_bytes == '0) ? shfs_pkg::POS_W'(1) : cfg.frame_bytes;
    hdr_sum = win_r[2] + win_r[3] + win_r[4];
    hdr_hit = (pos_r >= shfs_pkg::POS_W'(shfs_pkg::WIN_DEPTH)) &&
              (win_r[0] == cfg.sync_first) && (win_r[1] == cfg.sync_second) &&
              (win_r[4] == cfg.header_tag) && (data_byte == hdr_sum);
    hdr_id  = {win_r[3], win_r[2]};
    id_diff = hdr_id - prev_r;
    buf_end = ({1'b0, pos_r} + 18'd1) >= {1'b0, fb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < shfs_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      pos_r    <= '0;
      phase_r  <= shfs_pkg::PH_HUNT;
      pair_r   <= '0;
      pend_v_r <= 1'b0;
      prev_r   <= shfs_pkg::FNUM_NONE;
      cnt_r    <= '0;
    end else begin
      for (int i = 0; i < shfs_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      pair_r   <= pair_nxt;
      pend_v_r <= pend_v_nxt;
      prev_r   <= prev_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_b_r <= pend_b_nxt;
  end

  always_comb begin
    for (int i = 0; i < shfs_pkg::WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    pair_nxt   = pair_r;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    prev_nxt   = prev_r;
    cnt_nxt    = cnt_r;
    push0      = 1'b0;
    push1      = 1'b0;
    res0       = '0;
    res1       = '0;
    end_res    = '0;

    if (byte_take) begin
      unique case (phase_r)
        shfs_pkg::PH_HUNT: begin
          if (hdr_hit) begin
            prev_nxt   = hdr_id;
            pair_nxt   = '0;
            pend_v_nxt = 1'b0;
            res0.kind         = shfs_pkg::KIND_HEADER;
            res0.frame_number = hdr_id;
            res0.frame_lost   = (prev_r != shfs_pkg::FNUM_NONE) &&
                                (id_diff != shfs_pkg::FNUM_W'(1));
            res0.header_seen  = 1'b1;
            if (cfg.samples_per_channel == '0) begin
              cnt_nxt             = cnt_r + shfs_pkg::FNUM_W'(1);
              phase_nxt           = shfs_pkg::PH_DONE;
              res0.frame_complete = 1'b1;
            end else begin
              phase_nxt = shfs_pkg::PH_COLLECT;
            end
            res0.completed_frames = cnt_nxt;
            push0 = 1'b1;
          end
        end
        shfs_pkg::PH_COLLECT: begin
          if (!pend_v_r) begin
            pend_v_nxt = 1'b1;
            pend_b_nxt = data_byte;
          end else begin
            pair_nxt   = pair_r + shfs_pkg::PAIRS_W'(1);
            pend_v_nxt = 1'b0;
            res0.kind         = shfs_pkg::KIND_PAIR;
            res0.sample_a     = pend_b_r;
            res0.sample_b     = data_byte;
            res0.pair_index   = pair_r;
            res0.header_seen  = 1'b1;
            if (({1'b0, pair_r} + 16'd1) >= {1'b0, cfg.samples_per_channel}) begin
              cnt_nxt             = cnt_r + shfs_pkg::FNUM_W'(1);
              phase_nxt           = shfs_pkg::PH_DONE;
              res0.frame_complete = 1'b1;
            end
            res0.completed_frames = cnt_nxt;
            push0 = 1'b1;
          end
        end
        shfs_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase

      for (int i = 0; i < shfs_pkg::WIN_DEPTH - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[shfs_pkg::WIN_DEPTH-1] = data_byte;

      if (buf_end) begin
        if (phase_nxt != shfs_pkg::PH_DONE) begin
          end_res.kind             = shfs_pkg::KIND_END;
          end_res.completed_frames = cnt_nxt;
          end_res.header_seen      = (phase_nxt == shfs_pkg::PH_COLLECT);
          if (push0) begin
            res1  = end_res;
            push1 = 1'b1;
          end else begin
            res0  = end_res;
            push0 = 1'b1;
          end
        end
        pos_nxt    = '0;
        phase_nxt  = shfs_pkg::PH_HUNT;
        pair_nxt   = '0;
        pend_v_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + shfs_pkg::POS_W'(1);
      end

      // flag the final result of this byte
      if (push1) begin
        res1.last_of_run = 1'b1;
      end else if (push0) begin
        res0.last_of_run = 1'b1;
      end
    end
  end

endmodule

// File: hdl/shfs_outq.sv
// four-entry result queue, takes up to two results a cycle, gives one while out_stall is low
module shfs_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push0,
  input  logic           push1,
  input  shfs_pkg::res_t res0,
  input  shfs_pkg::res_t res1,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output shfs_pkg::res_t head
);

  shfs_pkg::res_t mem_r [4];
  logic [1:0]     wr_r, wr_nxt;
  logic [1:0]     rd_r, rd_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic           pop;

  always_comb begin
    pop       = (cnt_r != 3'd0) && !out_stall;
    out_valid = (cnt_r != 3'd0);
    head      = mem_r[rd_r];
    room      = (cnt_r <= 3'd2);
    wr_nxt    = wr_r + {1'b0, push0} + {1'b0, push1};
    rd_nxt    = rd_r + {1'b0, pop};
    cnt_nxt   = cnt_r + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_r] <= res0;
    end
    if (push1) begin
      mem_r[wr_r + 2'd1] <= res1;
    end
  end

endmodule

// File: hdl/sync_header_frame_splitter_unit.sv
// top level of the sync header frame splitter: config registers and wiring
// Takes one stream byte per cycle and answers it in the same cycle into a
// four-entry result queue; a byte yields zero, one or two results (a header
// or sample pair, and an end report when that byte closes a buffer with no
// completed frame), and the queue drains one result per cycle, so the sustained
// rate is one byte per cycle unless the result side stalls or two-result bytes
// pile up. in_stall rises while fewer than two queue entries are free. Results
// come out in order, last_of_run marking the final result of each byte. The
// user must write the configuration registers via cfg_we/cfg_index/cfg_data
// only while the block is idle (unenforced); indexes past the list are ignored.
module sync_header_frame_splitter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [shfs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [shfs_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [shfs_pkg::FNUM_W-1:0]  out_frame_number,
  output logic                         out_frame_lost,
  output logic [7:0]                   out_sample_a,
  output logic [7:0]                   out_sample_b,
  output logic [shfs_pkg::PAIRS_W-1:0] out_pair_index,
  output logic                         out_frame_complete,
  output logic [shfs_pkg::FNUM_W-1:0]  out_completed_frames,
  output logic                         out_header_seen,
  output logic                         out_last_of_run
);

  shfs_pkg::cfg_t cfg_r;
  shfs_pkg::res_t res0, res1, head;
  logic           push0, push1, room, byte_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_bytes         <= 17'd4096;
      cfg_r.samples_per_channel <= 15'd2045;
      cfg_r.sync_first          <= 8'hAA;
      cfg_r.sync_second         <= 8'h55;
      cfg_r.header_tag          <= 8'hD0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shfs_pkg::CFG_FRAME_BYTES: cfg_r.frame_bytes <= cfg_data;
        shfs_pkg::CFG_SPC:         cfg_r.samples_per_channel <= cfg_data[14:0];
        shfs_pkg::CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data[7:0];
        shfs_pkg::CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_data[7:0];
        shfs_pkg::CFG_HEADER_TAG:  cfg_r.header_tag  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = !room;
  assign byte_take = in_valid && room;

  shfs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .push0     (push0),
    .push1     (push1),
    .res0      (res0),
    .res1      (res1)
  );

  shfs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind             = head.kind;
  assign out_frame_number     = head.frame_number;
  assign out_frame_lost       = head.frame_lost;
  assign out_sample_a         = head.sample_a;
  assign out_sample_b         = head.sample_b;
  assign out_pair_index       = head.pair_index;
  assign out_frame_complete   = head.frame_complete;
  assign out_completed_frames = head.completed_frames;
  assign out_header_seen      = head.header_seen;
  assign out_last_of_run      = head.last_of_run;

endmodule
